@@ rtl/twofish_block_cipher_defines.svh @@
// Assertion macros shared by the Twofish RTL.
// No dependencies; included by files that carry assertions.
`ifndef TWOFISH_BLOCK_CIPHER_DEFINES_SVH
`define TWOFISH_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define TF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("twofish check failed");
`define TF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("twofish check failed");
`else
`define TF_ASSERT(lbl, clk, rst_n, prop)
`define TF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/tf_pkg.sv @@
// Twofish constants, tables and the g/h, q and RS functions.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
package tf_pkg;

  localparam int ROUNDS    = 16;
  localparam int KS_STEPS  = 20;
  localparam int KS_CNT_W  = $clog2(KS_STEPS + 1);
  localparam int PAIR_BASE = 4;
  localparam int CFG_IDX_W = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  // Key length codes.
  localparam logic [1:0] KEYLEN_128 = 2'd0;
  localparam logic [1:0] KEYLEN_192 = 2'd1;

  // Direction codes.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [3:0][31:0] blk_t;

  localparam logic [3:0] Q0T [0:3][0:15] = '{
    '{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
    '{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
    '{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
    '{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}
  };
  localparam logic [3:0] Q1T [0:3][0:15] = '{
    '{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
    '{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
    '{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
    '{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}
  };
  localparam logic [7:0] MDS [0:3][0:3] = '{
    '{8'h01,8'hEF,8'h5B,8'h5B},
    '{8'h5B,8'hEF,8'hEF,8'h01},
    '{8'hEF,8'h5B,8'h01,8'hEF},
    '{8'hEF,8'h01,8'hEF,8'h5B}
  };
  localparam logic [7:0] RSM [0:3][0:7] = '{
    '{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
    '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
    '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
    '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}
  };
  localparam logic [8:0] MDS_POLY = 9'h169;
  localparam logic [8:0] RS_POLY  = 9'h14D;

  // One nibble mixing step of the q permutation.
  function automatic logic [3:0] q_mix(input logic [3:0] a, input logic [3:0] b);
    q_mix = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
  endfunction

  // q0 (sel low) or q1 (sel high) byte permutation.
  function automatic logic [7:0] q_fn(input logic sel, input logic [7:0] x);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] a1;
    logic [3:0] b1;
    a1 = x[7:4] ^ x[3:0];
    b1 = q_mix(x[7:4], x[3:0]);
    a  = sel ? Q1T[0][a1] : Q0T[0][a1];
    b  = sel ? Q1T[1][b1] : Q0T[1][b1];
    a1 = a ^ b;
    b1 = q_mix(a, b);
    q_fn = sel ? {Q1T[3][b1], Q1T[2][a1]} : {Q0T[3][b1], Q0T[2][a1]};
  endfunction

  // GF(2^8) product; a is a constant at every call site.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] x;
    logic [7:0] r;
    r = 8'h00;
    x = {1'b0, a};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = x << 1;
      if (x[8]) begin
        x = x ^ poly;
      end
    end
    gf_mul = r;
  endfunction

  // h function over list words l[0..k-1], k from 2 to 4.
  function automatic logic [31:0] h_fn(input logic [31:0] x, input blk_t l,
                                       input logic [2:0] k);
    logic [3:0][7:0] y;
    logic [31:0] z;
    logic [7:0] s;
    y = x;
    if (k >= 3'd4) begin
      y[0] = q_fn(1'b1, y[0]) ^ l[3][7:0];
      y[1] = q_fn(1'b0, y[1]) ^ l[3][15:8];
      y[2] = q_fn(1'b0, y[2]) ^ l[3][23:16];
      y[3] = q_fn(1'b1, y[3]) ^ l[3][31:24];
    end
    if (k >= 3'd3) begin
      y[0] = q_fn(1'b1, y[0]) ^ l[2][7:0];
      y[1] = q_fn(1'b1, y[1]) ^ l[2][15:8];
      y[2] = q_fn(1'b0, y[2]) ^ l[2][23:16];
      y[3] = q_fn(1'b0, y[3]) ^ l[2][31:24];
    end
    y[0] = q_fn(1'b1, q_fn(1'b0, q_fn(1'b0, y[0]) ^ l[1][7:0]) ^ l[0][7:0]);
    y[1] = q_fn(1'b0, q_fn(1'b0, q_fn(1'b1, y[1]) ^ l[1][15:8]) ^ l[0][15:8]);
    y[2] = q_fn(1'b1, q_fn(1'b1, q_fn(1'b0, y[2]) ^ l[1][23:16]) ^ l[0][23:16]);
    y[3] = q_fn(1'b0, q_fn(1'b1, q_fn(1'b1, y[3]) ^ l[1][31:24]) ^ l[0][31:24]);
    z = 32'h0;
    for (int i = 0; i < 4; i++) begin
      s = 8'h00;
      for (int j = 0; j < 4; j++) begin
        s = s ^ gf_mul(MDS[i][j], y[j], MDS_POLY);
      end
      z[8*i +: 8] = s;
    end
    h_fn = z;
  endfunction

  // RS code of one 64-bit key word into an S-box key word.
  function automatic logic [31:0] rs_fn(input logic [63:0] w);
    logic [31:0] z;
    logic [7:0] s;
    z = 32'h0;
    for (int r = 0; r < 4; r++) begin
      s = 8'h00;
      for (int j = 0; j < 8; j++) begin
        s = s ^ gf_mul(RSM[r][j], w[8*j +: 8], RS_POLY);
      end
      z[8*r +: 8] = s;
    end
    rs_fn = z;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

endpackage

@@ rtl/tf_if.sv @@
// Valid/ready channel interfaces for the Twofish block and result words.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
interface tf_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] block_low;
  logic [63:0] block_high;
  modport source(output valid, output operation, output block_low, output block_high,
                 input ready);
  modport sink(input valid, input operation, input block_low, input block_high,
               output ready);
endinterface

interface tf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  modport source(output valid, output result_low, output result_high, input ready);
  modport sink(input valid, input result_low, input result_high, output ready);
endinterface

@@ rtl/twofish_block_cipher.sv @@
// Twofish top level: key schedule sequencer and unrolled round pipeline.
// Depends on tf_pkg, tf_if.sv and twofish_block_cipher_defines.svh.
// Path from accepted word to result word: input whitening stage, round stages, output register.
// Throughput: one block per cycle while the result word is not held and no key schedule runs;
// each round is a g stage and a Feistel stage. After reset and after each key register write
// the key schedule runs its 20 subkey pair steps, during which no word is accepted.
// Reset is asynchronous, active low; it clears the key to all zeros.
`timescale 1ns / 1ps
`include "twofish_block_cipher_defines.svh"
module twofish_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tf_in_if.sink                         in_if,
  tf_out_if.source                      out_if,
  input  logic                          cfg_we_i,
  input  logic [tf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [63:0]                   cfg_data_i
);

  localparam int R = tf_pkg::ROUNDS;

  // Key registers and schedule control.
  logic [63:0]                 key_q [0:3];
  logic [1:0]                  key_len_q;
  logic                        ks_busy_q;
  logic [tf_pkg::KS_CNT_W-1:0] ks_cnt_q;
  logic                        ks_v_q;
  logic [31:0]                 ks_a_q;
  logic [31:0]                 ks_b_q;
  logic [63:0]                 sk_q [0:tf_pkg::KS_STEPS-1];
  tf_pkg::blk_t                lk_q;
  logic [2:0]                  kw_q;

  logic                        cfg_hit;
  logic [2:0]                  kw_d;
  tf_pkg::blk_t                me;
  tf_pkg::blk_t                mo;
  tf_pkg::blk_t                lk_d;
  logic [31:0]                 sw [0:3];
  logic [7:0]                  ks_ev_byte;
  logic [7:0]                  ks_od_byte;
  logic [31:0]                 ks_a_d;
  logic [31:0]                 ks_b_d;
  logic [31:0]                 pair_even;
  logic [31:0]                 pair_odd;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= tf_pkg::REG_KEY_LENGTH);

  // Word count of the key; code three saturates to 256 bits.
  always_comb begin
    case (key_len_q)
      tf_pkg::KEYLEN_128: kw_d = 3'd2;
      tf_pkg::KEYLEN_192: kw_d = 3'd3;
      default:            kw_d = 3'd4;
    endcase
  end

  // Even and odd key halves, and S-box key words in g order.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      me[i] = key_q[i][31:0];
      mo[i] = key_q[i][63:32];
      sw[i] = tf_pkg::rs_fn(key_q[i]);
    end
    lk_d = '0;
    case (kw_d)
      3'd2: begin
        lk_d[0] = sw[1];
        lk_d[1] = sw[0];
      end
      3'd3: begin
        lk_d[0] = sw[2];
        lk_d[1] = sw[1];
        lk_d[2] = sw[0];
      end
      default: begin
        lk_d[0] = sw[3];
        lk_d[1] = sw[2];
        lk_d[2] = sw[1];
        lk_d[3] = sw[0];
      end
    endcase
  end

  // One subkey pair step: two h evaluations, then the PHT.
  assign ks_ev_byte = {2'b00, ks_cnt_q, 1'b0};
  assign ks_od_byte = {2'b00, ks_cnt_q, 1'b1};
  assign ks_a_d     = tf_pkg::h_fn({4{ks_ev_byte}}, me, kw_d);
  assign ks_b_d     = tf_pkg::rol(tf_pkg::h_fn({4{ks_od_byte}}, mo, kw_d), 8);
  assign pair_even  = ks_a_q + ks_b_q;
  assign pair_odd   = tf_pkg::rol(ks_a_q + {ks_b_q[30:0], 1'b0}, 9);

  // Key registers and the schedule sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= 64'h0;
      end
      key_len_q <= tf_pkg::KEYLEN_128;
      ks_busy_q <= 1'b1;
      ks_cnt_q  <= '0;
      ks_v_q    <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        tf_pkg::REG_KEY_WORD0:  key_q[0] <= cfg_data_i;
        tf_pkg::REG_KEY_WORD1:  key_q[1] <= cfg_data_i;
        tf_pkg::REG_KEY_WORD2:  key_q[2] <= cfg_data_i;
        tf_pkg::REG_KEY_WORD3:  key_q[3] <= cfg_data_i;
        default:                key_len_q <= cfg_data_i[1:0];
      endcase
      ks_busy_q <= 1'b1;
      ks_cnt_q  <= '0;
      ks_v_q    <= 1'b0;
    end else if (ks_busy_q) begin
      if (ks_cnt_q < tf_pkg::KS_CNT_W'(tf_pkg::KS_STEPS)) begin
        ks_cnt_q <= ks_cnt_q + 1'b1;
        ks_v_q   <= 1'b1;
      end else begin
        ks_v_q <= 1'b0;
        if (!ks_v_q) begin
          ks_busy_q <= 1'b0;
        end
      end
    end
  end

  // Schedule data: pair step registers, subkey shift line, g key words.
  always_ff @(posedge clk_i) begin
    ks_a_q <= ks_a_d;
    ks_b_q <= ks_b_d;
    if (ks_v_q) begin
      for (int i = 0; i < tf_pkg::KS_STEPS - 1; i++) begin
        sk_q[i] <= sk_q[i+1];
      end
      sk_q[tf_pkg::KS_STEPS-1] <= {pair_odd, pair_even};
    end
    if (ks_busy_q) begin
      lk_q <= lk_d;
      kw_q <= kw_d;
    end
  end

  // Pipeline advance: everything moves unless the result word is held.
  logic         adv;
  logic         in_acc;
  tf_pkg::blk_t x_q   [0:R];
  logic         op_q  [0:R];
  logic         v_q   [0:R];
  tf_pkg::blk_t gx_q  [0:R-1];
  logic [31:0]  gt0_q [0:R-1];
  logic [31:0]  gt1_q [0:R-1];
  logic         gop_q [0:R-1];
  logic         gv_q  [0:R-1];
  tf_pkg::blk_t out_q;
  logic         out_v_q;
  tf_pkg::blk_t in_blk;
  tf_pkg::blk_t in_wh;
  tf_pkg::blk_t out_wh;

  assign adv         = !out_v_q || out_if.ready;
  assign in_if.ready = adv && !ks_busy_q;
  assign in_acc      = in_if.valid && in_if.ready;
  assign in_blk      = {in_if.block_high, in_if.block_low};

  // Whitening keys: encryption uses keys 0..3 in, 4..7 out; decryption swaps them.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (in_if.operation == tf_pkg::OP_DECRYPT) begin
        in_wh[i] = sk_q[2 + i/2][32*(i%2) +: 32];
      end else begin
        in_wh[i] = sk_q[i/2][32*(i%2) +: 32];
      end
      if (op_q[R] == tf_pkg::OP_DECRYPT) begin
        out_wh[i] = sk_q[i/2][32*(i%2) +: 32];
      end else begin
        out_wh[i] = sk_q[2 + i/2][32*(i%2) +: 32];
      end
    end
  end

  // Input whitening stage and output register: valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0]  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0]  <= in_acc;
      out_v_q <= v_q[R];
    end
  end

  // Input whitening stage and output register: data.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]  <= in_blk ^ in_wh;
      op_q[0] <= in_if.operation;
      out_q   <= x_q[R] ^ out_wh;
    end
  end

  // Round stages: a g stage and a Feistel stage per round.
  for (genvar r = 0; r < R; r++) begin : g_round
    localparam int PE = tf_pkg::PAIR_BASE + r;
    localparam int PD = tf_pkg::PAIR_BASE + R - 1 - r;
    logic [31:0]  t0;
    logic [31:0]  t1;
    logic [63:0]  rk;
    logic [31:0]  f0;
    logic [31:0]  f1;
    logic [31:0]  n2;
    logic [31:0]  n3;
    tf_pkg::blk_t nx;

    assign t0 = tf_pkg::h_fn(x_q[r][0], lk_q, kw_q);
    assign t1 = tf_pkg::h_fn(tf_pkg::rol(x_q[r][1], 8), lk_q, kw_q);
    assign rk = (gop_q[r] == tf_pkg::OP_DECRYPT) ? sk_q[PD] : sk_q[PE];
    assign f0 = gt0_q[r] + gt1_q[r] + rk[31:0];
    assign f1 = gt0_q[r] + {gt1_q[r][30:0], 1'b0} + rk[63:32];

    // Feistel update, then the half swap on all but the last round.
    always_comb begin
      if (gop_q[r] == tf_pkg::OP_DECRYPT) begin
        n2 = tf_pkg::rol(gx_q[r][2], 1) ^ f0;
        n3 = tf_pkg::rol(gx_q[r][3] ^ f1, 31);
      end else begin
        n2 = tf_pkg::rol(gx_q[r][2] ^ f0, 31);
        n3 = tf_pkg::rol(gx_q[r][3], 1) ^ f1;
      end
      if (r == R - 1) begin
        nx = {n3, n2, gx_q[r][1], gx_q[r][0]};
      end else begin
        nx = {gx_q[r][1], gx_q[r][0], n3, n2};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        gv_q[r]  <= 1'b0;
        v_q[r+1] <= 1'b0;
      end else if (adv) begin
        gv_q[r]  <= v_q[r];
        v_q[r+1] <= gv_q[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        gx_q[r]    <= x_q[r];
        gt0_q[r]   <= t0;
        gt1_q[r]   <= t1;
        gop_q[r]   <= op_q[r];
        x_q[r+1]   <= nx;
        op_q[r+1]  <= gop_q[r];
      end
    end
  end

  assign out_if.valid       = out_v_q;
  assign out_if.result_low  = {out_q[1], out_q[0]};
  assign out_if.result_high = {out_q[3], out_q[2]};

  // Checks on the schedule sequencer and the pipeline end.
  `TF_ASSERT(a_ks_cnt_range, clk_i, rst_ni, ks_cnt_q <= tf_pkg::KS_CNT_W'(tf_pkg::KS_STEPS))
  `TF_ASSERT(a_ks_step_busy, clk_i, rst_ni, ks_v_q |-> ks_busy_q)
  `TF_ASSERT(a_ks_done_full, clk_i, rst_ni,
             $fell(ks_busy_q) |-> $past(ks_cnt_q) == tf_pkg::KS_CNT_W'(tf_pkg::KS_STEPS))
  `TF_ASSERT(a_out_from_last, clk_i, rst_ni, $rose(out_v_q) |-> $past(v_q[R]))

endmodule
